### rtl/core/vni_pkg.sv
// Shared constants, types and helper functions of the voxel neighbor index generator.
`timescale 1ns / 1ps

package vni_pkg;

    localparam int MAX_EXTENT = 1024;
    localparam int IDX_W      = 30;
    localparam int CFG_W      = 11;
    localparam int CW         = $clog2(MAX_EXTENT);
    localparam int EW         = $clog2(MAX_EXTENT + 1);
    localparam int SXY_W      = 2 * EW;
    localparam int TOT_W      = 3 * EW;
    localparam int CMP_W      = (TOT_W > IDX_W) ? TOT_W : IDX_W;

    localparam int DIV_STEPS  = 2;
    localparam int Q1_BITS    = 2 * CW;
    localparam int Q2_BITS    = CW + (CW % 2);
    localparam int Q1_CYC     = Q1_BITS / DIV_STEPS;
    localparam int Q2_CYC     = Q2_BITS / DIV_STEPS;
    localparam int CNT_W      = $clog2(Q1_CYC + 1);

    localparam int NB         = 27;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int SETTLE_CYC = 2;
    localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SIZE_X = 3'd0;
    localparam t_cfg_idx CFG_SIZE_Y = 3'd1;
    localparam t_cfg_idx CFG_SIZE_Z = 3'd2;
    localparam t_cfg_idx CFG_DIMS   = 3'd3;
    localparam t_cfg_idx CFG_MOORE  = 3'd4;

    localparam logic [1:0] DIMS_3D = 2'd3;

    localparam int AXIS_Z = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_X = 2;
    localparam int OFS_NEG = 0;
    localparam int OFS_POS = 2;

    typedef struct packed {
        logic [EW-1:0]    sx;
        logic [EW-1:0]    sy;
        logic [EW-1:0]    sz;
        logic             moore;
        logic [SXY_W-1:0] sxy;
        logic [TOT_W-1:0] total;
        logic             busy;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] v;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [CW-1:0]    z;
        logic             err;
    } t_item;

    function automatic logic [EW-1:0] clamp_ext(input logic [CFG_W-1:0] raw);
        logic [EW-1:0] res;
        if (raw == '0) begin
            res = EW'(1);
        end else if (int'(raw) > MAX_EXTENT) begin
            res = EW'(MAX_EXTENT);
        end else begin
            res = EW'(raw);
        end
        return res;
    endfunction

    // Neighbor slots 0..26 are ordered dz, dy, dx with each offset coded 0, 1, 2.
    function automatic logic [NB-1:0] nb_mask(input int axis, input int code);
        logic [NB-1:0] m;
        int            d;
        m = '0;
        for (int k = 0; k < NB; k++) begin
            if (axis == AXIS_Z) begin
                d = k / 9;
            end else if (axis == AXIS_Y) begin
                d = (k / 3) % 3;
            end else begin
                d = k % 3;
            end
            m[k] = (d == code);
        end
        return m;
    endfunction

    localparam logic [NB-1:0] MZ_NEG = nb_mask(AXIS_Z, OFS_NEG);
    localparam logic [NB-1:0] MZ_POS = nb_mask(AXIS_Z, OFS_POS);
    localparam logic [NB-1:0] MY_NEG = nb_mask(AXIS_Y, OFS_NEG);
    localparam logic [NB-1:0] MY_POS = nb_mask(AXIS_Y, OFS_POS);
    localparam logic [NB-1:0] MX_NEG = nb_mask(AXIS_X, OFS_NEG);
    localparam logic [NB-1:0] MX_POS = nb_mask(AXIS_X, OFS_POS);

endpackage

### rtl/core/vni_cfg.sv
// Configuration registers, extent clamping and registered grid products.
`timescale 1ns / 1ps

module vni_cfg import vni_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    output t_cfg             o_cfg
);

    logic [CFG_W-1:0]    r_size_x;
    logic [CFG_W-1:0]    r_size_y;
    logic [CFG_W-1:0]    r_size_z;
    logic [1:0]          r_dims;
    logic                r_moore;
    logic [SETTLE_W-1:0] r_settle;
    logic [SXY_W-1:0]    r_sxy;
    logic [TOT_W-1:0]    r_total;

    logic [EW-1:0] sx;
    logic [EW-1:0] sy;
    logic [EW-1:0] sz;

    assign sx = clamp_ext(r_size_x);
    assign sy = clamp_ext(r_size_y);
    assign sz = (r_dims == DIMS_3D) ? clamp_ext(r_size_z) : EW'(1);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= CFG_W'(128);
            r_size_y <= CFG_W'(128);
            r_size_z <= CFG_W'(64);
            r_dims   <= DIMS_3D;
            r_moore  <= 1'b1;
            r_settle <= SETTLE_W'(SETTLE_CYC);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                CFG_DIMS:   r_dims   <= i_cfg_data[1:0];
                CFG_MOORE:  r_moore  <= i_cfg_data[0];
                default: begin
                end
            endcase
            r_settle <= SETTLE_W'(SETTLE_CYC);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sxy   <= SXY_W'(sx) * SXY_W'(sy);
        r_total <= TOT_W'(r_sxy) * TOT_W'(sz);
    end

    assign o_cfg.sx    = sx;
    assign o_cfg.sy    = sy;
    assign o_cfg.sz    = sz;
    assign o_cfg.moore = r_moore;
    assign o_cfg.sxy   = r_sxy;
    assign o_cfg.total = r_total;
    assign o_cfg.busy  = (r_settle != '0);

endmodule

### rtl/core/vni_front.sv
// Front end: input beat buffer, range check and coordinate split by a shared radix-4 divider.
`timescale 1ns / 1ps

module vni_front import vni_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [IDX_W-1:0] i_voxel_index,
    input  t_cfg             i_cfg,
    output logic             o_push,
    output t_item            o_item,
    input  logic             i_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV1,
        F_DIV2,
        F_PUSH
    } t_fstate;

    t_fstate            r_state;
    logic               r_in_valid;
    logic [IDX_W-1:0]   r_in_v;
    logic [IDX_W-1:0]   r_v;
    logic               r_err;
    logic [EW-1:0]      r_rem;
    logic [Q1_BITS-1:0] r_dq;
    logic [CNT_W-1:0]   r_cnt;
    logic [CW-1:0]      r_x;
    logic [CW-1:0]      r_y;
    logic [CW-1:0]      r_z;

    logic [EW-1:0]      div_d;
    logic [EW:0]        s_rem2;
    logic               s_qbit;
    logic [EW-1:0]      s_rem;
    logic [Q1_BITS-1:0] s_dq;

    assign o_in_stall = r_in_valid;
    assign div_d      = (r_state == F_DIV1) ? i_cfg.sx : i_cfg.sy;

    always_comb begin
        s_rem  = r_rem;
        s_dq   = r_dq;
        s_rem2 = '0;
        s_qbit = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            s_rem2 = {s_rem, s_dq[Q1_BITS-1]};
            if (s_rem2 >= {1'b0, div_d}) begin
                s_rem2 = s_rem2 - {1'b0, div_d};
                s_qbit = 1'b1;
            end else begin
                s_qbit = 1'b0;
            end
            s_rem = s_rem2[EW-1:0];
            s_dq  = {s_dq[Q1_BITS-2:0], s_qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !r_in_valid) begin
                r_in_valid <= 1'b1;
                r_in_v     <= i_voxel_index;
            end
            unique case (r_state)
                F_IDLE: begin
                    if (r_in_valid && !i_cfg.busy) begin
                        r_in_valid <= 1'b0;
                        r_v        <= r_in_v;
                        r_cnt      <= '0;
                        if (CMP_W'(r_in_v) >= CMP_W'(i_cfg.total)) begin
                            r_err   <= 1'b1;
                            r_state <= F_PUSH;
                        end else begin
                            r_err   <= 1'b0;
                            r_rem   <= EW'(r_in_v >> Q1_BITS);
                            r_dq    <= r_in_v[Q1_BITS-1:0];
                            r_state <= F_DIV1;
                        end
                    end
                end
                F_DIV1: begin
                    if (r_cnt == CNT_W'(Q1_CYC - 1)) begin
                        r_x     <= CW'(s_rem);
                        r_rem   <= EW'(s_dq >> Q2_BITS);
                        r_dq    <= s_dq << (Q1_BITS - Q2_BITS);
                        r_cnt   <= '0;
                        r_state <= F_DIV2;
                    end else begin
                        r_rem <= s_rem;
                        r_dq  <= s_dq;
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                F_DIV2: begin
                    r_rem <= s_rem;
                    r_dq  <= s_dq;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(Q2_CYC - 1)) begin
                        r_y     <= CW'(s_rem);
                        r_z     <= CW'(s_dq[Q2_BITS-1:0]);
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_item.v   = r_v;
    assign o_item.x   = r_x;
    assign o_item.y   = r_y;
    assign o_item.z   = r_z;
    assign o_item.err = r_err;

endmodule

### rtl/core/vni_fifo.sv
// Short queue of classified voxels between front end and back end.
`timescale 1ns / 1ps

module vni_fifo import vni_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/vni_back.sv
// Back end: neighbor mask build, ascending scan and result output register.
`timescale 1ns / 1ps

module vni_back import vni_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_empty,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_neighbor_index,
    output logic             o_last_of_run,
    output logic             o_no_neighbor,
    output logic             o_index_error
);

    logic             r_busy;
    logic [NB-1:0]    r_mask;
    logic [IDX_W-1:0] r_v;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_last;
    logic             r_none;
    logic             r_err;

    logic             xlo;
    logic             xhi;
    logic             ylo;
    logic             yhi;
    logic             zlo;
    logic             zhi;
    logic [NB-1:0]    load_mask;
    logic [NB-1:0]    onehot;
    logic [NB-1:0]    rest;
    logic             last;
    logic [IDX_W-1:0] sxy_w;
    logic [IDX_W-1:0] sx_w;
    logic [IDX_W-1:0] zt;
    logic [IDX_W-1:0] yt;
    logic [IDX_W-1:0] xt;
    logic [IDX_W-1:0] nb_idx;
    logic             out_free;

    assign xlo = (i_item.x != '0);
    assign ylo = (i_item.y != '0);
    assign zlo = (i_item.z != '0);
    assign xhi = ((EW'(i_item.x) + EW'(1)) < i_cfg.sx);
    assign yhi = ((EW'(i_item.y) + EW'(1)) < i_cfg.sy);
    assign zhi = ((EW'(i_item.z) + EW'(1)) < i_cfg.sz);

    for (genvar k = 0; k < NB; k++) begin : g_mask
        localparam int DZ = k / 9;
        localparam int DY = (k / 3) % 3;
        localparam int DX = k % 3;
        localparam int NZ = int'(DZ != 1) + int'(DY != 1) + int'(DX != 1);
        logic okz;
        logic oky;
        logic okx;
        assign okz = (DZ == OFS_NEG) ? zlo : ((DZ == OFS_POS) ? zhi : 1'b1);
        assign oky = (DY == OFS_NEG) ? ylo : ((DY == OFS_POS) ? yhi : 1'b1);
        assign okx = (DX == OFS_NEG) ? xlo : ((DX == OFS_POS) ? xhi : 1'b1);
        assign load_mask[k] = okz && oky && okx && (NZ != 0) && (i_cfg.moore || (NZ == 1));
    end

    assign onehot = r_mask & (~r_mask + NB'(1));
    assign rest   = r_mask & ~onehot;
    assign last   = (rest == '0);

    assign sxy_w = IDX_W'(i_cfg.sxy);
    assign sx_w  = IDX_W'(i_cfg.sx);
    assign zt = (|(onehot & MZ_NEG)) ? -sxy_w : ((|(onehot & MZ_POS)) ? sxy_w : '0);
    assign yt = (|(onehot & MY_NEG)) ? -sx_w  : ((|(onehot & MY_POS)) ? sx_w  : '0);
    assign xt = (|(onehot & MX_NEG)) ? '1     : ((|(onehot & MX_POS)) ? IDX_W'(1) : '0);
    assign nb_idx = r_v + zt + yt + xt;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = out_free && !r_busy && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free && r_busy) begin
                r_out_valid <= 1'b1;
                r_idx       <= nb_idx;
                r_last      <= last;
                r_none      <= 1'b0;
                r_err       <= 1'b0;
                r_mask      <= rest;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end else if (o_pop) begin
                if (i_item.err) begin
                    r_out_valid <= 1'b1;
                    r_idx       <= '0;
                    r_last      <= 1'b1;
                    r_none      <= 1'b0;
                    r_err       <= 1'b1;
                end else if (load_mask == '0) begin
                    r_out_valid <= 1'b1;
                    r_idx       <= '0;
                    r_last      <= 1'b1;
                    r_none      <= 1'b1;
                    r_err       <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                    r_busy      <= 1'b1;
                    r_mask      <= load_mask;
                    r_v         <= i_item.v;
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_neighbor_index = r_idx;
    assign o_last_of_run    = r_last;
    assign o_no_neighbor    = r_none;
    assign o_index_error    = r_err;

endmodule

### rtl/core/voxel_neighbor_index_generator_core.sv
// Top level of the voxel neighbor index generator.
// Front end per voxel: range check, then x and then y and z from the shared
// 2-bit-per-cycle divider (skipped for an out-of-range index), then a queue push;
// a second voxel waits in the input buffer. Back end: a load step per voxel, then
// one result beat per cycle while the output is not stalled; a 4-entry queue lets
// front and back stall independently.
// Reset is synchronous: 128 x 128 x 64 3D Moore grid; input waits after reset
// or any register write while the grid products settle.
`timescale 1ns / 1ps

module voxel_neighbor_index_generator_core import vni_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [IDX_W-1:0] i_voxel_index,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_neighbor_index,
    output logic             o_last_of_run,
    output logic             o_no_neighbor,
    output logic             o_index_error,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_item push_item;
    t_item head_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    vni_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    vni_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_voxel_index (i_voxel_index),
        .i_cfg         (cfg),
        .o_push        (push),
        .o_item        (push_item),
        .i_full        (full)
    );

    vni_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_item)
    );

    vni_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_empty          (empty),
        .i_item           (head_item),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_neighbor_index (o_neighbor_index),
        .o_last_of_run    (o_last_of_run),
        .o_no_neighbor    (o_no_neighbor),
        .o_index_error    (o_index_error)
    );

endmodule

### rtl/core/vni_checker.sv
// Port-level checker of the voxel neighbor index generator and its bind.
`timescale 1ns / 1ps

module vni_checker import vni_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [IDX_W-1:0] o_neighbor_index,
    input logic             o_last_of_run,
    input logic             o_no_neighbor,
    input logic             o_index_error
);

    logic             out_acc;
    logic             r_run_open;
    logic [IDX_W-1:0] r_prev;

    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
        end else if (out_acc) begin
            r_run_open <= !o_last_of_run;
            r_prev     <= o_neighbor_index;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_neighbor_index)
            && $stable(o_last_of_run) && $stable(o_no_neighbor) && $stable(o_index_error))
        else $error("stalled result beat changed");

    a_flag_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_index_error || o_no_neighbor) |->
            o_last_of_run && (o_neighbor_index == '0) && !(o_index_error && o_no_neighbor))
        else $error("flagged result beat malformed");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_run_open |->
            !o_index_error && !o_no_neighbor && (o_neighbor_index > r_prev))
        else $error("neighbor run not strictly ascending");

endmodule

bind voxel_neighbor_index_generator_core vni_checker u_vni_checker (.*);
